// File: sv/brc_pkg.sv
// shared constants and types for the bright region centroid block
package brc_pkg;

	// default sizes of the frame store and of one frame dimension
	localparam int MAX_PIXELS_DEF = 32768;
	localparam int MAX_DIM_DEF    = 1024;

	// field widths
	localparam int PIX_W      = 8;
	localparam int CFG_DIM_W  = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int OUT_CRD_W  = 10;
	localparam int OUT_NORM_W = 16;
	localparam int OUT_CNT_W  = 16;

	// fixed point format of the normalized position
	localparam int Q_FRAC = 15;

	// floor(d / 6) for an 8-bit d as (d * 171) >> 10
	localparam int RECIP6_MUL   = 171;
	localparam int RECIP6_SHIFT = 10;
	localparam int RECIP6_W     = 16;

	// register reset values
	localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = 11'd160;
	localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = 11'd120;
	localparam logic [PIX_W-1:0]     MIN_CONTRAST_RST = 8'd25;

	// frame state reset values
	localparam logic [PIX_W-1:0] LEVEL_MIN_RST = 8'hff;
	localparam logic [PIX_W-1:0] LEVEL_MAX_RST = 8'h00;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_MIN_CONTRAST = 2'd2
	} cfg_reg_t;

	// status of the divider: busy and done
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// File: sv/brc_div.sv
// restoring divider, one quotient bit per cycle
module brc_div #(
	parameter int DVD_W = 32,
	parameter int DVS_W = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [DVD_W-1:0]             dividend,
	input  logic [DVS_W-1:0]             divisor,
	output brc_pkg::div_status_t         status,
	output logic [DVD_W-1:0]             quotient
);

	localparam int CW = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   diff;
	logic             ge;

	// one trial subtraction
	always_comb begin
		shifted = {rem_q, quo_q[DVD_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = shifted >= {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule

// File: sv/bright_region_centroid_top.sv
// bright region centroid: frame store, threshold scan and centroid division
// Pixels are taken one per cycle while the frame fills; the item marked last starts
// the evaluation: setup in PREP and LIMIT, a scan of min(stored pixels, width*height)
// reads at one per cycle (no reads when the contrast test fails), then 4 divisions
// on the shared divider when any pixel passed, then the RESULT state raises done.
// Reset clears control and registers at once; the frame store has no clearing pass
// and only entries written in the current frame are read. Results cannot be stalled.
module bright_region_centroid_top #(
	parameter int MAX_PIXELS = brc_pkg::MAX_PIXELS_DEF,
	parameter int MAX_DIM    = brc_pkg::MAX_DIM_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// pixel requests
	input  logic                                 start,
	output logic                                 busy,
	input  logic [brc_pkg::PIX_W-1:0]            pixel,
	input  logic                                 last_pixel,
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [brc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [brc_pkg::CFG_DATA_W-1:0]       cfg_data,
	// result
	output logic                                 done,
	output logic                                 found,
	output logic [brc_pkg::OUT_CRD_W-1:0]        centroid_x,
	output logic [brc_pkg::OUT_CRD_W-1:0]        centroid_y,
	output logic signed [brc_pkg::OUT_NORM_W-1:0] norm_x,
	output logic signed [brc_pkg::OUT_NORM_W-1:0] norm_y,
	output logic [brc_pkg::OUT_CNT_W-1:0]        bright_count,
	output logic [brc_pkg::PIX_W-1:0]            min_level,
	output logic [brc_pkg::PIX_W-1:0]            max_level
);

	localparam int AW    = $clog2(MAX_PIXELS);
	localparam int CNT_W = $clog2(MAX_PIXELS + 1);
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CRD_W = $clog2(MAX_DIM);
	localparam int SUM_W = AW + CRD_W;
	localparam int NUM_W = DIM_W + brc_pkg::Q_FRAC;
	localparam int DVD_W = (SUM_W > NUM_W) ? SUM_W : NUM_W;
	localparam int DVS_W = (CNT_W > DIM_W) ? CNT_W : DIM_W;
	localparam int PRD_W = 2 * DIM_W;
	localparam int LIM_W = (PRD_W > CNT_W) ? PRD_W : CNT_W;
	localparam int NW    = DIM_W + 1;
	localparam int PW    = brc_pkg::PIX_W;
	localparam int QW    = brc_pkg::OUT_NORM_W;
	localparam int Q_ONE = 1 << brc_pkg::Q_FRAC;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_PREP     = 7'b0000010,
		ST_LIMIT    = 7'b0000100,
		ST_SCAN     = 7'b0001000,
		ST_DIV_GO   = 7'b0010000,
		ST_DIV_WAIT = 7'b0100000,
		ST_RESULT   = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		OP_CX = 2'd0,
		OP_CY = 2'd1,
		OP_NX = 2'd2,
		OP_NY = 2'd3
	} op_t;

	state_t state_q;
	op_t    op_q;

	// configuration registers
	logic [brc_pkg::CFG_DIM_W-1:0] frame_width_q;
	logic [brc_pkg::CFG_DIM_W-1:0] frame_height_q;
	logic [PW-1:0]                 min_contrast_q;

	// frame state
	logic [PW-1:0]    mem [MAX_PIXELS];
	logic [CNT_W-1:0] wcount_q;
	logic [PW-1:0]    min_q;
	logic [PW-1:0]    max_q;

	// evaluation registers
	logic [DIM_W-1:0] w_q;
	logic [DIM_W-1:0] h_q;
	logic [PW-1:0]    diff_q;
	logic [PW-1:0]    thr_q;
	logic [CNT_W-1:0] limit_q;
	logic [CNT_W-1:0] addr_q;
	logic [CRD_W-1:0] col_q;
	logic [CRD_W-1:0] row_q;
	logic             rd_v_s1;
	logic [PW-1:0]    rdata_s1;
	logic [CRD_W-1:0] col_s1;
	logic [CRD_W-1:0] row_s1;
	logic [SUM_W-1:0] sum_col_q;
	logic [SUM_W-1:0] sum_row_q;
	logic [CNT_W-1:0] hit_q;
	logic [CRD_W-1:0] cx_q;
	logic [CRD_W-1:0] cy_q;
	logic [QW-1:0]    nx_q;
	logic [QW-1:0]    ny_q;
	logic             neg_q;

	// result registers
	logic                          done_q;
	logic                          found_q;
	logic [brc_pkg::OUT_CRD_W-1:0] cx_out_q;
	logic [brc_pkg::OUT_CRD_W-1:0] cy_out_q;
	logic [QW-1:0]                 nx_out_q;
	logic [QW-1:0]                 ny_out_q;
	logic [brc_pkg::OUT_CNT_W-1:0] cnt_out_q;
	logic [PW-1:0]                 min_out_q;
	logic [PW-1:0]                 max_out_q;

	logic                 accept;
	logic                 store_en;
	logic                 issuing;
	logic                 hit;
	logic [PRD_W-1:0]     prod;
	logic [LIM_W-1:0]     prod_ext;
	logic [LIM_W-1:0]     cnt_ext;
	logic                 contrast_ok;
	logic [brc_pkg::RECIP6_W-1:0] recip_prod;
	logic [PW-1:0]        sixth;
	logic [CRD_W-1:0]     coord_sel;
	logic [DIM_W-1:0]     size_sel;
	logic [NW-1:0]        twice;
	logic [NW-1:0]        size_ext;
	logic                 norm_neg;
	logic [NW-1:0]        mag;
	logic                 div_start;
	logic [DVD_W-1:0]     div_dividend;
	logic [DVS_W-1:0]     div_divisor;
	brc_pkg::div_status_t div_status;
	logic [DVD_W-1:0]     div_quotient;
	logic [QW-1:0]        norm_q15;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign store_en  = accept && (wcount_q < CNT_W'(MAX_PIXELS));
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= brc_pkg::FRAME_WIDTH_RST;
			frame_height_q <= brc_pkg::FRAME_HEIGHT_RST;
			min_contrast_q <= brc_pkg::MIN_CONTRAST_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				brc_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				brc_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				brc_pkg::REG_MIN_CONTRAST: min_contrast_q <= cfg_data[PW-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic [AW-1:0] addr_idx(input logic [CNT_W-1:0] a);
		addr_idx = a[AW-1:0];
	endfunction

	// frame store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (store_en) begin
			mem[addr_idx(wcount_q)] <= pixel;
		end
		if (issuing) begin
			rdata_s1 <= mem[addr_idx(addr_q)];
		end
	end

	// threshold, limit and contrast test
	always_comb begin
		recip_prod  = brc_pkg::RECIP6_W'(diff_q) * brc_pkg::RECIP6_W'(brc_pkg::RECIP6_MUL);
		sixth       = PW'(recip_prod >> brc_pkg::RECIP6_SHIFT);
		prod        = PRD_W'(w_q) * PRD_W'(h_q);
		prod_ext    = LIM_W'(prod);
		cnt_ext     = LIM_W'(wcount_q);
		contrast_ok = diff_q > min_contrast_q;
	end

	// scan issue and hit test
	assign issuing = (state_q == ST_SCAN) && (addr_q < limit_q);
	assign hit     = rd_v_s1 && (rdata_s1 >= thr_q);

	// normalization operands for the divider
	always_comb begin
		coord_sel = (op_q == OP_NX) ? cx_q : cy_q;
		size_sel  = (op_q == OP_NX) ? w_q : h_q;
		twice     = NW'({coord_sel, 1'b0});
		size_ext  = NW'(size_sel);
		norm_neg  = twice < size_ext;
		mag       = norm_neg ? (size_ext - twice) : (twice - size_ext);
	end

	always_comb begin
		div_start = (state_q == ST_DIV_GO);
		unique case (op_q)
			OP_CX: begin
				div_dividend = DVD_W'(sum_col_q);
				div_divisor  = DVS_W'(hit_q);
			end
			OP_CY: begin
				div_dividend = DVD_W'(sum_row_q);
				div_divisor  = DVS_W'(hit_q);
			end
			default: begin
				div_dividend = DVD_W'({mag[DIM_W-1:0], {brc_pkg::Q_FRAC{1'b0}}});
				div_divisor  = DVS_W'(size_sel);
			end
		endcase
	end

	brc_div #(
		.DVD_W(DVD_W),
		.DVS_W(DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.status   (div_status),
		.quotient (div_quotient)
	);

	// sign and saturation of the normalized quotient
	always_comb begin
		if (!neg_q) begin
			norm_q15 = (div_quotient > DVD_W'(Q_ONE - 1)) ? QW'(Q_ONE - 1)
				: div_quotient[QW-1:0];
		end else begin
			norm_q15 = (div_quotient > DVD_W'(Q_ONE)) ? QW'(Q_ONE)
				: (~div_quotient[QW-1:0] + QW'(1));
		end
	end

	// sequencer and frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= OP_CX;
			wcount_q <= '0;
			min_q    <= brc_pkg::LEVEL_MIN_RST;
			max_q    <= brc_pkg::LEVEL_MAX_RST;
			rd_v_s1  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			rd_v_s1 <= issuing;
			unique case (state_q)
				ST_IDLE: begin
					if (store_en) begin
						wcount_q <= wcount_q + CNT_W'(1);
						if (pixel > max_q) begin
							max_q <= pixel;
						end
						if (pixel < min_q) begin
							min_q <= pixel;
						end
					end
					if (accept && last_pixel) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_LIMIT;
				end
				ST_LIMIT: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (!issuing && !rd_v_s1) begin
						op_q    <= OP_CX;
						state_q <= (hit_q != '0) ? ST_DIV_GO : ST_RESULT;
					end
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_status.done) begin
						if (op_q == OP_NY) begin
							state_q <= ST_RESULT;
						end else begin
							op_q    <= op_t'(op_q + 2'd1);
							state_q <= ST_DIV_GO;
						end
					end
				end
				ST_RESULT: begin
					done_q   <= 1'b1;
					wcount_q <= '0;
					min_q    <= brc_pkg::LEVEL_MIN_RST;
					max_q    <= brc_pkg::LEVEL_MAX_RST;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// evaluation datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			diff_q <= max_q - min_q;
			if (frame_width_q == '0) begin
				w_q <= DIM_W'(1);
			end else if (32'(frame_width_q) > MAX_DIM) begin
				w_q <= DIM_W'(MAX_DIM);
			end else begin
				w_q <= DIM_W'(frame_width_q);
			end
			if (frame_height_q == '0) begin
				h_q <= DIM_W'(1);
			end else if (32'(frame_height_q) > MAX_DIM) begin
				h_q <= DIM_W'(MAX_DIM);
			end else begin
				h_q <= DIM_W'(frame_height_q);
			end
		end
		if (state_q == ST_LIMIT) begin
			thr_q     <= max_q - sixth;
			limit_q   <= !contrast_ok ? '0
				: (prod_ext < cnt_ext) ? CNT_W'(prod_ext) : wcount_q;
			addr_q    <= '0;
			col_q     <= '0;
			row_q     <= '0;
			sum_col_q <= '0;
			sum_row_q <= '0;
			hit_q     <= '0;
		end
		// address walk with column and row
		if (issuing) begin
			addr_q <= addr_q + CNT_W'(1);
			col_s1 <= col_q;
			row_s1 <= row_q;
			if (DIM_W'(col_q) + DIM_W'(1) == w_q) begin
				col_q <= '0;
				row_q <= row_q + CRD_W'(1);
			end else begin
				col_q <= col_q + CRD_W'(1);
			end
		end
		// accumulate bright pixels
		if (hit) begin
			sum_col_q <= sum_col_q + SUM_W'(col_s1);
			sum_row_q <= sum_row_q + SUM_W'(row_s1);
			hit_q     <= hit_q + CNT_W'(1);
		end
		if (state_q == ST_DIV_GO) begin
			neg_q <= norm_neg;
		end
		// quotients
		if (state_q == ST_DIV_WAIT && div_status.done) begin
			unique case (op_q)
				OP_CX: cx_q <= CRD_W'(div_quotient);
				OP_CY: cy_q <= CRD_W'(div_quotient);
				OP_NX: nx_q <= norm_q15;
				OP_NY: ny_q <= norm_q15;
				default: ;
			endcase
		end
		// result register
		if (state_q == ST_RESULT) begin
			found_q   <= (hit_q != '0);
			cx_out_q  <= (hit_q != '0) ? brc_pkg::OUT_CRD_W'(cx_q) : '0;
			cy_out_q  <= (hit_q != '0) ? brc_pkg::OUT_CRD_W'(cy_q) : '0;
			nx_out_q  <= (hit_q != '0) ? nx_q : '0;
			ny_out_q  <= (hit_q != '0) ? ny_q : '0;
			cnt_out_q <= brc_pkg::OUT_CNT_W'(hit_q);
			min_out_q <= min_q;
			max_out_q <= max_q;
		end
	end

	assign done         = done_q;
	assign found        = found_q;
	assign centroid_x   = cx_out_q;
	assign centroid_y   = cy_out_q;
	assign norm_x       = nx_out_q;
	assign norm_y       = ny_out_q;
	assign bright_count = cnt_out_q;
	assign min_level    = min_out_q;
	assign max_level    = max_out_q;

endmodule

// File: test/bright_region_centroid_top_tb.sv
// self-checking testbench for the bright region centroid block
module bright_region_centroid_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// index with no register behind it, writes there are ignored
	localparam logic [brc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int RANDOM_PIXELS = 1400;
	localparam int PHASE_PIXELS  = 175;
	localparam int CALM_PIXELS   = 150;

	typedef struct packed {
		logic                           found;
		logic [brc_pkg::OUT_CRD_W-1:0]  cx;
		logic [brc_pkg::OUT_CRD_W-1:0]  cy;
		logic [brc_pkg::OUT_NORM_W-1:0] nx;
		logic [brc_pkg::OUT_NORM_W-1:0] ny;
		logic [brc_pkg::OUT_CNT_W-1:0]  count;
		logic [brc_pkg::PIX_W-1:0]      lo;
		logic [brc_pkg::PIX_W-1:0]      hi;
	} centroid_t;

	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t                       kind;
		logic [brc_pkg::PIX_W-1:0]       pix;
		logic                            last;
		bit                              typed;
		centroid_t                       want;
		logic [brc_pkg::CFG_IDX_W-1:0]   idx;
		logic [brc_pkg::CFG_DATA_W-1:0]  val;
	} dir_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic [brc_pkg::PIX_W-1:0]       pixel;
	logic                            last_pixel;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [brc_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [brc_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                            done;
	logic                            found;
	logic [brc_pkg::OUT_CRD_W-1:0]   centroid_x;
	logic [brc_pkg::OUT_CRD_W-1:0]   centroid_y;
	logic signed [brc_pkg::OUT_NORM_W-1:0] norm_x;
	logic signed [brc_pkg::OUT_NORM_W-1:0] norm_y;
	logic [brc_pkg::OUT_CNT_W-1:0]   bright_count;
	logic [brc_pkg::PIX_W-1:0]       min_level;
	logic [brc_pkg::PIX_W-1:0]       max_level;

	bright_region_centroid_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel(pixel),
		.last_pixel(last_pixel),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.found(found),
		.centroid_x(centroid_x),
		.centroid_y(centroid_y),
		.norm_x(norm_x),
		.norm_y(norm_y),
		.bright_count(bright_count),
		.min_level(min_level),
		.max_level(max_level)
	);

	// predictor copy of registers and frame state
	logic [brc_pkg::CFG_DIM_W-1:0] cfg_w;
	logic [brc_pkg::CFG_DIM_W-1:0] cfg_h;
	logic [brc_pkg::PIX_W-1:0]     cfg_contrast;
	logic [brc_pkg::PIX_W-1:0]     frame_px [brc_pkg::MAX_PIXELS_DEF];
	int unsigned                   stored;
	int unsigned                   run_lo;
	int unsigned                   run_hi;

	centroid_t pending_centroids[$];
	dir_row_t  dir_rows[$];
	centroid_t got;
	centroid_t want;
	int        mismatch_count;
	int        results_seen;
	int        bright_frames;
	int        pixels_sent;
	int        reg_writes;
	int        rand_base;
	int        phase;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int unsigned dim_of(input logic [brc_pkg::CFG_DIM_W-1:0] v);
		if (v < 1) return 1;
		if (v > brc_pkg::MAX_DIM_DEF) return brc_pkg::MAX_DIM_DEF;
		return v;
	endfunction

	// signed q1.15 offset of a position from the frame center, saturated
	function automatic logic [brc_pkg::OUT_NORM_W-1:0] q15_offset(input int unsigned c,
			input int unsigned size);
		longint num;
		longint q;
		num = (2 * longint'(c) - longint'(size)) * (longint'(1) << brc_pkg::Q_FRAC);
		q = num / longint'(size);
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[brc_pkg::OUT_NORM_W-1:0];
	endfunction

	function automatic centroid_t make_result(input logic f, input int cx, input int cy,
			input int nx, input int ny, input int cnt, input int lo, input int hi);
		centroid_t r;
		r.found = f;
		r.cx    = brc_pkg::OUT_CRD_W'(cx);
		r.cy    = brc_pkg::OUT_CRD_W'(cy);
		r.nx    = brc_pkg::OUT_NORM_W'(nx);
		r.ny    = brc_pkg::OUT_NORM_W'(ny);
		r.count = brc_pkg::OUT_CNT_W'(cnt);
		r.lo    = brc_pkg::PIX_W'(lo);
		r.hi    = brc_pkg::PIX_W'(hi);
		return r;
	endfunction

	// store one accepted pixel, on the last one work out the frame result
	task automatic track_pixel(input logic [brc_pkg::PIX_W-1:0] p, input logic l,
			input bit typed, input centroid_t typed_want);
		int unsigned w, h, span, thr, col, row, scol, srow, hits, cx, cy, i;
		centroid_t r;
		if (stored < brc_pkg::MAX_PIXELS_DEF) begin
			frame_px[stored] = p;
			stored++;
			if (p > run_hi) run_hi = p;
			if (p < run_lo) run_lo = p;
		end
		if (!l) return;
		w = dim_of(cfg_w);
		h = dim_of(cfg_h);
		span = w * h;
		if (span > stored) span = stored;
		thr = run_hi - (run_hi - run_lo) / 6;
		scol = 0;
		srow = 0;
		hits = 0;
		// second pass over the stored frame
		if (run_hi - run_lo > cfg_contrast) begin
			col = 0;
			row = 0;
			for (i = 0; i < span; i++) begin
				if (frame_px[i] >= thr) begin
					scol += col;
					srow += row;
					hits++;
				end
				col++;
				if (col == w) begin
					col = 0;
					row++;
				end
			end
		end
		cx = (hits > 0) ? scol / hits : 0;
		cy = (hits > 0) ? srow / hits : 0;
		r.found = (hits > 0);
		r.cx    = brc_pkg::OUT_CRD_W'(cx);
		r.cy    = brc_pkg::OUT_CRD_W'(cy);
		r.nx    = (hits > 0) ? q15_offset(cx, w) : '0;
		r.ny    = (hits > 0) ? q15_offset(cy, h) : '0;
		r.count = brc_pkg::OUT_CNT_W'(hits);
		r.lo    = brc_pkg::PIX_W'(run_lo);
		r.hi    = brc_pkg::PIX_W'(run_hi);
		pending_centroids.push_back(typed ? typed_want : r);
		stored = 0;
		run_lo = 255;
		run_hi = 0;
	endtask

	// one pixel request, held until the block takes it
	task automatic send_pixel(input logic [brc_pkg::PIX_W-1:0] p, input logic l,
			input bit typed, input centroid_t typed_want);
		@(negedge clk);
		start      <= 1'b1;
		pixel      <= p;
		last_pixel <= l;
		cfg_valid  <= 1'b0;
		@(posedge clk);
		while (busy) @(posedge clk);
		track_pixel(p, l, typed, typed_want);
		pixels_sent++;
	endtask

	// sender gap with junk on the payload
	task automatic pause_sender(input int n);
		repeat (n) begin
			@(negedge clk);
			start      <= 1'b0;
			pixel      <= brc_pkg::PIX_W'($urandom);
			last_pixel <= 1'($urandom);
		end
	endtask

	// stop requesting and let every pending result come out
	task automatic wait_drained();
		@(negedge clk);
		start     <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_centroids.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [brc_pkg::CFG_IDX_W-1:0] idx,
			input logic [brc_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		start     <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			brc_pkg::REG_FRAME_WIDTH:  cfg_w = val;
			brc_pkg::REG_FRAME_HEIGHT: cfg_h = val;
			brc_pkg::REG_MIN_CONTRAST: cfg_contrast = val[brc_pkg::PIX_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// directed table helpers
	task automatic add_pixel(input logic [brc_pkg::PIX_W-1:0] p, input logic l);
		dir_row_t r;
		r.kind  = ROW_PIXEL;
		r.pix   = p;
		r.last  = l;
		r.typed = 1'b0;
		r.want  = '0;
		r.idx   = '0;
		r.val   = '0;
		dir_rows.push_back(r);
	endtask

	task automatic add_checked(input logic [brc_pkg::PIX_W-1:0] p, input centroid_t w);
		dir_row_t r;
		r.kind  = ROW_PIXEL;
		r.pix   = p;
		r.last  = 1'b1;
		r.typed = 1'b1;
		r.want  = w;
		r.idx   = '0;
		r.val   = '0;
		dir_rows.push_back(r);
	endtask

	task automatic add_write(input logic [brc_pkg::CFG_IDX_W-1:0] idx,
			input logic [brc_pkg::CFG_DATA_W-1:0] val);
		dir_row_t r;
		r.kind  = ROW_WRITE;
		r.pix   = '0;
		r.last  = 1'b0;
		r.typed = 1'b0;
		r.want  = '0;
		r.idx   = idx;
		r.val   = val;
		dir_rows.push_back(r);
	endtask

	// one random frame shaped like a picture, sometimes of the wrong length
	task automatic run_random_frame(input bit calm);
		int unsigned w, h, area, len, mode, bg, base, spread, c0, c1, r0, r1, i, col, row;
		logic [brc_pkg::PIX_W-1:0] p;
		w = dim_of(cfg_w);
		h = dim_of(cfg_h);
		area = w * h;
		if (area > 64) area = 64;
		len = ($urandom_range(0, 9) < 7) ? area : $urandom_range(1, area + 8);
		mode = $urandom_range(0, 9);
		bg = $urandom_range(0, 120);
		base = $urandom_range(0, 230);
		spread = $urandom_range(0, 25);
		c0 = $urandom_range(0, w - 1);
		c1 = $urandom_range(c0, w - 1);
		r0 = $urandom_range(0, h - 1);
		r1 = $urandom_range(r0, h - 1);
		for (i = 0; i < len; i++) begin
			col = i % w;
			row = i / w;
			if (mode < 3) begin
				p = brc_pkg::PIX_W'($urandom_range(0, 255));
			end else if (mode < 8) begin
				// bright rectangle on a dim noisy background
				if (col >= c0 && col <= c1 && row >= r0 && row <= r1)
					p = brc_pkg::PIX_W'($urandom_range(150, 255));
				else
					p = brc_pkg::PIX_W'(bg + $urandom_range(0, 20));
			end else begin
				// flat picture, contrast close to the limit
				p = brc_pkg::PIX_W'(base + $urandom_range(0, spread));
			end
			send_pixel(p, i == len - 1, 1'b0, '0);
			if (!calm && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 10));
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			got = {found, centroid_x, centroid_y, norm_x, norm_y, bright_count,
				min_level, max_level};
			results_seen++;
			if (got.found === 1'b1) bright_frames++;
			if (pending_centroids.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected result: found=%0d x=%0d y=%0d n=%0d",
						got.found, got.cx, got.cy, got.count);
				mismatch_count++;
			end else begin
				want = pending_centroids.pop_front();
				if (got.found !== want.found || got.cx !== want.cx || got.cy !== want.cy ||
						got.nx !== want.nx || got.ny !== want.ny ||
						got.count !== want.count || got.lo !== want.lo ||
						got.hi !== want.hi) begin
					if (mismatch_count < 10) begin
						$display("want found=%0d x=%0d y=%0d nx=%0d ny=%0d n=%0d lo=%0d hi=%0d",
							want.found, want.cx, want.cy, $signed(want.nx),
							$signed(want.ny), want.count, want.lo, want.hi);
						$display("got  found=%0d x=%0d y=%0d nx=%0d ny=%0d n=%0d lo=%0d hi=%0d",
							got.found, got.cx, got.cy, $signed(got.nx),
							$signed(got.ny), got.count, got.lo, got.hi);
					end
					mismatch_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		pixel        = '0;
		last_pixel   = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		cfg_w        = brc_pkg::FRAME_WIDTH_RST;
		cfg_h        = brc_pkg::FRAME_HEIGHT_RST;
		cfg_contrast = brc_pkg::MIN_CONTRAST_RST;
		stored       = 0;
		run_lo       = 255;
		run_hi       = 0;
		mismatch_count = 0;
		results_seen   = 0;
		bright_frames  = 0;
		pixels_sent    = 0;
		reg_writes     = 0;

		// lone pixels and a two pixel frame under reset settings
		add_checked(8'd0, make_result(0, 0, 0, 0, 0, 0, 0, 0));
		add_checked(8'd255, make_result(0, 0, 0, 0, 0, 0, 255, 255));
		add_pixel(8'd0, 1'b0);
		add_checked(8'd255, make_result(1, 1, 0, -32358, -32768, 1, 0, 255));
		// contrast equal to the limit, then one above; upper data bits ignored
		add_write(brc_pkg::REG_MIN_CONTRAST, 11'h709);
		add_pixel(8'd10, 1'b0);
		add_checked(8'd19, make_result(0, 0, 0, 0, 0, 0, 10, 19));
		add_pixel(8'd10, 1'b0);
		add_pixel(8'd20, 1'b1);
		add_write(REG_SPARE, 11'h5a5);
		// zero width and oversized height are clamped
		add_write(brc_pkg::REG_FRAME_WIDTH, 11'd0);
		add_write(brc_pkg::REG_FRAME_HEIGHT, 11'd2047);
		add_pixel(8'd0, 1'b0);
		add_pixel(8'd200, 1'b0);
		add_pixel(8'd200, 1'b1);
		// frames longer and shorter than width times height
		add_write(brc_pkg::REG_FRAME_WIDTH, 11'd2);
		add_write(brc_pkg::REG_FRAME_HEIGHT, 11'd2);
		add_write(brc_pkg::REG_MIN_CONTRAST, 11'd0);
		add_pixel(8'd0, 1'b0);
		add_pixel(8'd0, 1'b0);
		add_pixel(8'd0, 1'b0);
		add_pixel(8'd0, 1'b0);
		add_pixel(8'd255, 1'b1);
		add_pixel(8'd77, 1'b0);
		add_checked(8'd77, make_result(0, 0, 0, 0, 0, 0, 77, 77));
		add_pixel(8'd255, 1'b0);
		add_pixel(8'd0, 1'b1);
		// largest sizes, contrast limit that can never be passed
		add_write(brc_pkg::REG_FRAME_WIDTH, 11'd1024);
		add_write(brc_pkg::REG_FRAME_HEIGHT, 11'd1024);
		add_write(brc_pkg::REG_MIN_CONTRAST, 11'd255);
		add_pixel(8'd0, 1'b0);
		add_checked(8'd255, make_result(0, 0, 0, 0, 0, 0, 0, 255));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_WRITE) begin
				wait_drained();
				write_reg(dir_rows[k].idx, dir_rows[k].val);
			end else begin
				send_pixel(dir_rows[k].pix, dir_rows[k].last, dir_rows[k].typed,
					dir_rows[k].want);
				if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 10));
			end
		end

		// random frames over several register settings
		rand_base = pixels_sent;
		phase = 0;
		while (pixels_sent - rand_base < RANDOM_PIXELS) begin
			if (pixels_sent - rand_base >= phase * PHASE_PIXELS) begin
				wait_drained();
				case (phase)
					0: begin
						write_reg(brc_pkg::REG_FRAME_WIDTH, 11'd0);
						write_reg(brc_pkg::REG_FRAME_HEIGHT, 11'd2047);
						write_reg(brc_pkg::REG_MIN_CONTRAST, 11'd0);
					end
					1: begin
						write_reg(brc_pkg::REG_FRAME_WIDTH, 11'd1024);
						write_reg(brc_pkg::REG_FRAME_HEIGHT, 11'd0);
						write_reg(brc_pkg::REG_MIN_CONTRAST, 11'h7c8);
					end
					default: begin
						write_reg(brc_pkg::REG_FRAME_WIDTH,
							brc_pkg::CFG_DATA_W'($urandom_range(1, 12)));
						write_reg(brc_pkg::REG_FRAME_HEIGHT,
							brc_pkg::CFG_DATA_W'($urandom_range(1, 8)));
						write_reg(brc_pkg::REG_MIN_CONTRAST, {3'($urandom_range(0, 7)),
							($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
							8'($urandom_range(0, 40))});
					end
				endcase
				phase++;
			end
			run_random_frame(pixels_sent - rand_base >= RANDOM_PIXELS - CALM_PIXELS);
		end

		wait_drained();
		repeat (200) @(posedge clk);

		$display("checked %0d results from %0d pixels, %0d with a bright region",
			results_seen, pixels_sent, bright_frames);
		$display("%0d register writes over %0d random settings, clamped sizes included",
			reg_writes, phase);
		if (mismatch_count == 0 && pending_centroids.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
